/* design/u8l1_pkg.sv */
package u8l1_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ReplResetVal = 8'h3F;
  localparam logic [ByteW-1:0] AsciiMax     = 8'd126;
  localparam logic [ByteW-1:0] Latin1Min    = 8'd160;

  localparam logic [ByteW-1:0] Mask2 = 8'hE0;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Mask3 = 8'hF0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Mask4 = 8'hF8;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] MaskC = 8'hC0;
  localparam logic [ByteW-1:0] ContC = 8'h80;

  localparam logic [1:0] Skip3Byte = 2'd2;
  localparam logic [1:0] Skip4Byte = 2'd3;

  // results of one input byte: one or two bytes
  typedef struct packed {
    logic             pair;
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/u8l1_front.sv */
module u8l1_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [u8l1_pkg::ByteW-1:0] in_byte_i,
  input  logic                    in_eol_i,
  input  logic [u8l1_pkg::ByteW-1:0] repl_i,
  input  u8l1_pkg::q_stat_t       q_stat_i,
  output logic                    push_o,
  output u8l1_pkg::entry_t        entry_o
);
  import u8l1_pkg::*;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHold = 2'd1,
    PhSkip = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  held_q, held_d;
  logic [1:0]  skip_q, skip_d;

  logic        accept;
  logic        is_cont;
  logic        fr_emit;
  logic [ByteW-1:0] fr_byte;
  phase_e      fr_phase;
  logic [4:0]  fr_held;
  logic [1:0]  fr_skip;
  logic [10:0] val2;
  logic [1:0]  n_out;
  logic [ByteW-1:0] o0, o1;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cont    = (in_byte_i & MaskC) == ContC;
  assign val2       = {held_q, in_byte_i[5:0]};

  // fresh decode of the incoming byte
  always_comb begin
    fr_emit  = 1'b1;
    fr_byte  = repl_i;
    fr_phase = PhIdle;
    fr_held  = held_q;
    fr_skip  = 2'd0;
    if (in_byte_i <= AsciiMax) begin
      fr_byte = in_byte_i;
    end else if ((in_byte_i & Mask2) == Lead2) begin
      if (!in_eol_i) begin
        fr_emit  = 1'b0;
        fr_phase = PhHold;
        fr_held  = in_byte_i[4:0];
      end
    end else if ((in_byte_i & Mask3) == Lead3) begin
      fr_phase = PhSkip;
      fr_skip  = Skip3Byte;
    end else if ((in_byte_i & Mask4) == Lead4) begin
      fr_phase = PhSkip;
      fr_skip  = Skip4Byte;
    end
  end

  always_comb begin
    n_out   = 2'd0;
    o0      = fr_byte;
    o1      = fr_byte;
    phase_d = PhIdle;
    held_d  = held_q;
    skip_d  = 2'd0;
    if (phase_q == PhHold) begin
      held_d = 5'd0;
      if (is_cont) begin
        n_out = 2'd1;
        if (val2[10:8] == 3'd0 && val2[7:0] >= Latin1Min) begin
          o0 = val2[7:0];
        end else begin
          o0 = repl_i;
        end
      end else begin
        o0      = repl_i;
        n_out   = fr_emit ? 2'd2 : 2'd1;
        phase_d = fr_phase;
        held_d  = (fr_phase == PhHold) ? fr_held : 5'd0;
        skip_d  = fr_skip;
      end
    end else if (phase_q == PhSkip && skip_q != 2'd0 && is_cont) begin
      skip_d  = skip_q - 2'd1;
      phase_d = (skip_q == 2'd1) ? PhIdle : PhSkip;
    end else begin
      n_out   = fr_emit ? 2'd1 : 2'd0;
      phase_d = fr_phase;
      held_d  = fr_held;
      skip_d  = fr_skip;
    end
    if (in_eol_i) begin
      phase_d = PhIdle;
      held_d  = 5'd0;
      skip_d  = 2'd0;
    end
  end

  assign push_o         = accept && (n_out != 2'd0);
  assign entry_o.pair   = n_out == 2'd2;
  assign entry_o.first  = o0;
  assign entry_o.second = o1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 5'd0;
      skip_q  <= 2'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      skip_q  <= skip_d;
    end
  end

endmodule

/* design/u8l1_queue.sv */
module u8l1_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8l1_pkg::entry_t  wdata_i,
  input  logic              pop_i,
  output u8l1_pkg::entry_t  rdata_o,
  output u8l1_pkg::q_stat_t stat_o
);
  import u8l1_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = cnt_q == FullCnt;
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/u8l1_back.sv */
module u8l1_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  u8l1_pkg::entry_t           head_i,
  input  u8l1_pkg::q_stat_t          q_stat_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u8l1_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_last_o
);
  import u8l1_pkg::*;

  logic sel_q;
  logic xfer;

  assign out_valid_o = !q_stat_i.empty;
  assign out_byte_o  = sel_q ? head_i.second : head_i.first;
  assign out_last_o  = sel_q || !head_i.pair;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && out_last_o;

  // second byte of a pair follows the first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (xfer) begin
      sel_q <= !out_last_o;
    end
  end

endmodule

/* design/utf8_to_latin1_transcoder.sv */
// UTF-8 to Latin-1 transcoder
//
// Input stream: s_axis_tdata carries one UTF-8 byte, s_axis_tlast marks the
// last byte of a line. Output stream: m_axis_tdata carries one Latin-1 byte,
// m_axis_tlast marks the last output byte caused by one input byte.
// cfg_we_i/cfg_wdata_i write the replacement byte; write it only while idle.
//
// Each result is registered in the queue as its input byte is accepted.
// Throughput: one input byte per cycle while the queue is not full; a byte
// that yields two results is sent as two output bytes, and bytes that yield
// none (held leads, swallowed continuations) push no entry. A queue of
// QueueDepth entries sits between decode and output, so the input keeps
// going while the receiver stalls until that queue fills, then s_axis_tready
// drops. Reset empties the queue, clears the decoder state and sets the
// replacement byte to a question mark.
module utf8_to_latin1_transcoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_line
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_run
);
  import u8l1_pkg::*;

  logic [ByteW-1:0] repl_q;
  logic             push, pop;
  entry_t           wentry, head;
  q_stat_t          q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplResetVal;
    end else if (cfg_we_i) begin
      repl_q <= cfg_wdata_i;
    end
  end

  u8l1_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eol_i   (s_axis_tlast),
    .repl_i     (repl_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (wentry)
  );

  u8l1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (head),
    .stat_o  (q_stat)
  );

  u8l1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* design/u8l1_checker.sv */
module u8l1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // input back-pressure only with results waiting
  a_ready_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with nothing to deliver");

  // second byte of a pair is ready straight away
  a_pair_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of a pair missing");

  // after a non-last byte the next one closes the run
  a_pair_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tlast)
    else $error("run longer than two results");

  // input ready is known whenever input valid is high
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tready))
    else $error("input ready unknown");

endmodule

bind utf8_to_latin1_transcoder u8l1_checker u_chk (.*);

/* tb/sv/utf8_latin1_checker.sv */
module utf8_latin1_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_line
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic       m_axis_tlast,   // last_of_run
  output int         fail_count_o,
  output int         pending_o
);
  import u8l1_pkg::*;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHold = 2'd1,
    PhSkip = 2'd2
  } dec_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_end;
  } latin1_out_t;

  logic [ByteW-1:0] repl_byte;
  dec_phase_e       dec_phase;
  logic [4:0]       held_bits;
  logic [1:0]       skip_left;
  logic [ByteW-1:0] step_out[$];
  latin1_out_t      latin1_expected[$];
  int               fails;

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return (b & MaskC) == ContC;
  endfunction

  function void take_fresh(input logic [ByteW-1:0] b, input logic eol);
    if (b <= AsciiMax) begin
      step_out.push_back(b);
    end else if ((b & Mask2) == Lead2) begin
      if (eol) begin
        step_out.push_back(repl_byte);
      end else begin
        dec_phase = PhHold;
        held_bits = b[4:0];
      end
    end else if ((b & Mask3) == Lead3) begin
      step_out.push_back(repl_byte);
      dec_phase = PhSkip;
      skip_left = Skip3Byte;
    end else if ((b & Mask4) == Lead4) begin
      step_out.push_back(repl_byte);
      dec_phase = PhSkip;
      skip_left = Skip4Byte;
    end else begin
      step_out.push_back(repl_byte);
    end
  endfunction

  function void decode_byte(input logic [ByteW-1:0] b, input logic eol);
    logic [10:0] code;
    latin1_out_t item;
    step_out.delete();
    if (dec_phase == PhHold) begin
      dec_phase = PhIdle;
      if (is_cont(b)) begin
        code = {held_bits, b[5:0]};
        if (code[10:8] == 3'd0 && code[7:0] >= Latin1Min) begin
          step_out.push_back(code[7:0]);
        end else begin
          step_out.push_back(repl_byte);
        end
        held_bits = '0;
      end else begin
        held_bits = '0;
        step_out.push_back(repl_byte);
        take_fresh(b, eol);
      end
    end else if (dec_phase == PhSkip && skip_left != 2'd0) begin
      if (is_cont(b)) begin
        skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0) begin
          dec_phase = PhIdle;
        end
      end else begin
        dec_phase = PhIdle;
        skip_left = '0;
        take_fresh(b, eol);
      end
    end else begin
      dec_phase = PhIdle;
      skip_left = '0;
      take_fresh(b, eol);
    end
    if (eol) begin
      dec_phase = PhIdle;
      held_bits = '0;
      skip_left = '0;
    end
    for (int i = 0; i < step_out.size(); i++) begin
      item.out_byte = step_out[i];
      item.run_end  = (i == step_out.size() - 1);
      latin1_expected.push_back(item);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    latin1_out_t want;
    if (!rst_ni) begin
      repl_byte = ReplResetVal;
      dec_phase = PhIdle;
      held_bits = '0;
      skip_left = '0;
      latin1_expected.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (latin1_expected.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %0b", $time,
                   m_axis_tdata, m_axis_tlast);
          fails++;
        end else begin
          want = latin1_expected.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, m_axis_tdata);
            fails++;
          end
          if (m_axis_tlast !== want.run_end) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.run_end, m_axis_tlast);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        repl_byte = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
      end
    end
    fail_count_o <= fails;
    pending_o    <= latin1_expected.size();
  end

endmodule

/* tb/sv/tb_utf8_to_latin1_transcoder.sv */
module tb_utf8_to_latin1_transcoder;

  localparam int CycleLimit = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;   // end_of_line
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;   // last_of_run

  int         mismatches;
  int         pending;
  int         idle_pct;
  int         stall_pct;
  int         bytes_sent;
  int         cycle_count;
  logic [7:0] line_q[$];

  utf8_to_latin1_transcoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf8_latin1_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (mismatches),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task send_line();
    logic [7:0] b;
    for (int i = 0; i < line_q.size(); i++) begin
      b = line_q[i];
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b;
      s_axis_tlast  <= (i == line_q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      bytes_sent++;
    end
  endtask

  // one character: mostly well-formed, some truncated sequences and noise
  task add_char();
    int kind;
    int n_cont;
    kind = $urandom_range(0, 9);
    n_cont = 0;
    case (kind)
      0, 1, 2, 3: begin
        line_q.push_back(8'($urandom_range(0, 126)));
      end
      4: begin
        line_q.push_back(8'(8'hC2 + $urandom_range(0, 1)));
        n_cont = 1;
      end
      5: begin
        line_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        n_cont = 1;
      end
      6: begin
        line_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        n_cont = 2;
      end
      7: begin
        line_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        n_cont = 3;
      end
      8: begin
        line_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
        n_cont = $urandom_range(0, 1);
      end
      default: begin
        line_q.push_back(8'($urandom_range(8'h7F, 8'hFF)));
      end
    endcase
    repeat (n_cont) line_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
  endtask

  task run_random(input int idle, input int stall, input int count);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      line_q.delete();
      repeat ($urandom_range(1, 8)) add_char();
      send_line();
    end
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task write_repl(input logic [7:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    cycle_count   = 0;
    bytes_sent    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass-through limits, two-byte limits, broken and long leads
    line_q = {8'h00, 8'h7E, 8'h7F, 8'h80, 8'hBF};
    send_line();
    line_q = {8'hC2, 8'hA0, 8'hC3, 8'hBF, 8'hC2, 8'h9F};
    send_line();
    line_q = {8'hC3, 8'h41, 8'hC3, 8'hC3, 8'hA9, 8'hC3, 8'hE2};
    send_line();
    line_q = {8'hC3};
    send_line();
    line_q = {8'hE2, 8'h82};
    send_line();
    line_q = {8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41, 8'hF8, 8'hFF};
    send_line();

    run_random(0, 0, 18);
    wait_drained();
    write_repl(8'hFF);
    run_random(82, 0, 18);
    wait_drained();
    write_repl(8'h00);
    run_random(0, 82, 18);
    wait_drained();
    write_repl(8'($urandom_range(0, 255)));
    run_random(6, 6, 18);
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/u8l1_pkg.sv
design/u8l1_front.sv
design/u8l1_queue.sv
design/u8l1_back.sv
design/utf8_to_latin1_transcoder.sv
design/u8l1_checker.sv
tb/sv/utf8_latin1_checker.sv
tb/sv/tb_utf8_to_latin1_transcoder.sv
